[hdl/spq_pkg.sv]
// shared types, constants and helpers of the stable priority queue
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    act_t        action;
    logic [7:0]  task_id;
    logic [7:0]  priority_req;
    logic [15:0] exec_time;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic             out_valid;
    logic [7:0]       out_task_id;
    logic [7:0]       out_priority;
    logic [15:0]      out_exec_time;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [7:0]  prio;
    logic [15:0] exec_time;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t fresh;
  } cell_ctl_t;

  function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[OCC_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/stable_priority_queue_core.sv]
// stable priority queue: a row of sorted cells with one registered response
//
// Usage: each request word on req (req_valid / req_ready) is either an insert
// (task id, priority, execution time) or a pop. Every request gives exactly one
// response word on rsp (rsp_valid / rsp_ready) carrying a status, the popped
// entry when there is one, and the occupancy after the request.
// Inserts go behind every stored entry of equal or higher priority, so equal
// priorities leave in arrival order; a pop returns the head slot.
// The response is registered when the request is accepted.
// Throughput: one request per cycle unless stalled; all cells compare against
// the new priority in parallel and shift by one slot in the same cycle.
// An insert into a full queue is dropped with status full; a pop on an empty
// queue returns status empty with zeroed entry fields.
// Reset (rst, synchronous) empties the queue and drops any pending response.
// When the receiver stalls, the response is held and req_ready stays low
// until it is taken, so no request is lost.
`default_nettype none

module stable_priority_queue_core
  import spq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output var  logic req_ready,
  input  var  req_t req,
  output var  logic rsp_valid,
  input  wire logic rsp_ready,
  output var  rsp_t rsp
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  rsp_t             rsp_next;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  cell_ctl_t        ctl;
  entry_t           cells [CAPACITY];
  logic             keeps [CAPACITY];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign is_empty  = (count == '0);

  always_comb begin
    ctl.insert          = accept && (req.action == ACT_INSERT) && !is_full;
    ctl.pop             = accept && (req.action == ACT_POP) && !is_empty;
    ctl.fresh.task_id   = req.task_id;
    ctl.fresh.prio      = req.priority_req;
    ctl.fresh.exec_time = req.exec_time;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   lkeep;
    entry_t lent;
    entry_t rent;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign lkeep = 1'b1;
      assign lent  = ctl.fresh;
    end else begin : g_mid
      assign lkeep = keeps[i-1];
      assign lent  = cells[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rent = '0;
    end else begin : g_body
      assign rent = cells[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .left_keep   (lkeep),
      .left_entry  (lent),
      .right_entry (rent),
      .entry       (cells[i]),
      .keep        (keeps[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.pop) begin
      count_next = count - CNT_W'(1);
    end

    rsp_next           = '0;
    rsp_next.status    = ST_OK;
    rsp_next.occupancy = occ_of(count_next);
    if (req.action == ACT_INSERT) begin
      if (is_full) begin
        rsp_next.status = ST_FULL;
      end
    end else if (is_empty) begin
      rsp_next.status = ST_EMPTY;
    end else begin
      rsp_next.out_valid     = 1'b1;
      rsp_next.out_task_id   = cells[0].task_id;
      rsp_next.out_priority  = cells[0].prio;
      rsp_next.out_exec_time = cells[0].exec_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_empty_pop : assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_POP && is_empty)
      |=> (rsp.status == ST_EMPTY && !rsp.out_valid && count == '0))
    else $error("pop on empty queue not flagged");

  a_insert_count : assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_INSERT && !is_full)
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the queue");

  a_head_sorted : assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (cells[0].prio >= cells[1].prio))
    else $error("head slot out of order");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

`default_nettype wire

[hdl/spq_cell.sv]
// one slot of the sorted shift-register queue
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  var  cell_ctl_t ctl,
  input  wire logic      occupied,
  input  wire logic      left_keep,
  input  var  entry_t    left_entry,
  input  var  entry_t    right_entry,
  output var  entry_t    entry,
  output var  logic      keep
);

  entry_t entry_next;

  // a stored entry of equal or higher priority stays ahead of the new one
  assign keep = occupied && (entry.prio >= ctl.fresh.prio);

  always_comb begin
    entry_next = entry;
    if (ctl.insert) begin
      if (!keep) begin
        entry_next = left_keep ? ctl.fresh : left_entry;
      end
    end else if (ctl.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

[bench/stable_priority_queue_core_tb.sv]
// testbench for stable_priority_queue_core: directed and random insert/pop traffic
`timescale 1ns / 100ps

module stable_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int QUIET_LIMIT = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // sorted copy of the queue, head at slot 0
  entry_t sorted_tbl [CAPACITY];
  int     tbl_count = 0;
  rsp_t   pending_rsp [$];
  int     errors = 0;
  int     quiet_cycles = 0;
  bit     calm = 1'b0;

  stable_priority_queue_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // applies one request to the sorted copy and returns the response it gives
  function automatic rsp_t queue_apply(input req_t w);
    rsp_t r;
    int   slot;
    int   i;
    r = '0;
    r.status = ST_OK;
    if (w.action == ACT_INSERT) begin
      if (tbl_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        slot = 0;
        while (slot < tbl_count && sorted_tbl[slot].prio >= w.priority_req) slot++;
        for (i = tbl_count; i > slot; i--) sorted_tbl[i] = sorted_tbl[i - 1];
        sorted_tbl[slot].task_id   = w.task_id;
        sorted_tbl[slot].prio      = w.priority_req;
        sorted_tbl[slot].exec_time = w.exec_time;
        tbl_count++;
      end
    end else if (tbl_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.out_valid     = 1'b1;
      r.out_task_id   = sorted_tbl[0].task_id;
      r.out_priority  = sorted_tbl[0].prio;
      r.out_exec_time = sorted_tbl[0].exec_time;
      for (i = 1; i < tbl_count; i++) sorted_tbl[i - 1] = sorted_tbl[i];
      tbl_count--;
    end
    r.occupancy = OCC_W'(tbl_count);
    return r;
  endfunction

  task automatic field_check(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  // request side updates the prediction, response side checks against it
  always @(posedge clk) begin
    rsp_t exp;
    if (!rst) begin
      if (req_valid && req_ready) pending_rsp.push_back(queue_apply(req));
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          $error("response word with no request pending");
          errors++;
        end else begin
          exp = pending_rsp.pop_front();
          field_check("status", 32'(exp.status), 32'(rsp.status));
          field_check("out_valid", 32'(exp.out_valid), 32'(rsp.out_valid));
          field_check("out_task_id", 32'(exp.out_task_id), 32'(rsp.out_task_id));
          field_check("out_priority", 32'(exp.out_priority), 32'(rsp.out_priority));
          field_check("out_exec_time", 32'(exp.out_exec_time), 32'(rsp.out_exec_time));
          field_check("occupancy", 32'(exp.occupancy), 32'(rsp.occupancy));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL stable_priority_queue_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: ready runs broken by stall bursts, steady ready once calm
  initial begin
    int  left;
    bit  stall;
    left = 0;
    stall = 1'b1;
    forever begin
      @(posedge clk);
      if (calm) begin
        rsp_ready <= 1'b1;
      end else begin
        if (left == 0) begin
          stall = !stall;
          left = stall ? $urandom_range(1, 14) : $urandom_range(1, 40);
        end
        rsp_ready <= !stall;
        left--;
      end
    end
  end

  task automatic send_word(input req_t w);
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic hold_off(input int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  function automatic req_t make_insert(input logic [7:0] tid, input logic [7:0] pri,
                                       input logic [15:0] tim);
    req_t w;
    w.action       = ACT_INSERT;
    w.task_id      = tid;
    w.priority_req = pri;
    w.exec_time    = tim;
    return w;
  endfunction

  // pop words carry random payload, which must be ignored
  function automatic req_t make_pop();
    req_t w;
    w = make_insert(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)));
    w.action = ACT_POP;
    return w;
  endfunction

  function automatic req_t rand_word(input int insert_pct);
    req_t w;
    logic [7:0] pri;
    logic [15:0] tim;
    case ($urandom_range(0, 5))
      0: pri = 8'($urandom_range(0, 255));
      1: pri = $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: pri = 8'($urandom_range(60, 63));  // clustered so ties are common
    endcase
    tim = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 16'hffff : 16'h0000)
                                       : 16'($urandom_range(0, 65535));
    if ($urandom_range(1, 100) <= insert_pct) w = make_insert(8'($urandom_range(0, 255)), pri, tim);
    else w = make_pop();
    return w;
  endfunction

  task automatic test_pop_on_empty();
    send_word(make_pop());
  endtask

  task automatic test_field_extremes();
    send_word(make_insert(8'h00, 8'h00, 16'h0000));
    send_word(make_insert(8'hff, 8'hff, 16'hffff));
    send_word(make_pop());
    send_word(make_pop());
    send_word(make_pop());
  endtask

  task automatic test_equal_priority_order();
    send_word(make_insert(8'h01, 8'h80, 16'h1111));
    send_word(make_insert(8'h02, 8'h80, 16'h2222));
    send_word(make_insert(8'h03, 8'hc0, 16'h3333));
    send_word(make_insert(8'h04, 8'h80, 16'h4444));
    send_word(make_insert(8'h05, 8'h7f, 16'h5555));
    send_word(make_pop());
  endtask

  task automatic test_full_drop();
    // hold the sender until the prediction has caught up, then fill exactly
    wait_drained();
    repeat (CAPACITY - tbl_count)
      send_word(make_insert(8'($urandom_range(0, 255)), 8'h80, 16'($urandom_range(0, 65535))));
    send_word(make_insert(8'haa, 8'hff, 16'hbeef));
    send_word(make_insert(8'h55, 8'h00, 16'h0001));
  endtask

  task automatic test_mixed_traffic(input int n_items);
    int done;
    int insert_pct;
    int gap_pct;
    bit drained;
    done = 0;
    drained = 1'b0;
    while (done < n_items) begin
      // phases lean toward filling or emptying so both ends are reached often
      case ($urandom_range(0, 3))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
      repeat (40) begin
        send_word(rand_word(insert_pct));
        done++;
        if ($urandom_range(1, 100) <= gap_pct) hold_off($urandom_range(1, 14));
      end
      if (!drained && done >= n_items / 2) begin
        wait_drained();
        drained = 1'b1;
      end
    end
  endtask

  task automatic test_back_to_back_tail(input int n_items);
    calm = 1'b1;
    repeat (n_items) send_word(rand_word(50));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_pop_on_empty();
    test_field_extremes();
    test_equal_priority_order();
    test_full_drop();
    test_mixed_traffic(880);
    test_back_to_back_tail(150);
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS stable_priority_queue_core");
    end else begin
      $display("FAIL stable_priority_queue_core");
    end
    $finish;
  end

endmodule
